@@ rtl/flow_pulse_rate_and_outage_monitor_defines.svh @@
`ifndef FLOW_PULSE_RATE_AND_OUTAGE_MONITOR_DEFINES_SVH
`define FLOW_PULSE_RATE_AND_OUTAGE_MONITOR_DEFINES_SVH

// clocked assertion, masked while reset is held
`define FPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked assertion that also runs during reset
`define FPM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/fpm_pkg.sv @@
`timescale 1ns / 1ps

package fpm_pkg;

  localparam int FPM_WINDOW_SLOTS = 10;

  localparam logic [15:0] FPM_THRESHOLD_RESET  = 16'd5;
  localparam logic [15:0] FPM_INIT_TICKS_RESET = 16'd100;

  typedef enum logic [2:0] {
    OP_PULSE       = 3'd0,
    OP_FILTER_TICK = 3'd1,
    OP_PERIOD_TICK = 3'd2,
    OP_START_CHECK = 3'd3,
    OP_STOP_CHECK  = 3'd4,
    OP_SET_OUTAGE  = 3'd5
  } fpm_op_t;

  typedef enum logic [0:0] {
    REG_THRESHOLD  = 1'b0,
    REG_INIT_TICKS = 1'b1
  } fpm_reg_t;

  // decoded operation of the word being processed this cycle
  typedef struct packed {
    logic pulse;
    logic filter_tick;
    logic period_tick;
    logic start_check;
    logic stop_check;
    logic set_outage;
  } fpm_evt_t;

  typedef struct packed {
    logic        init_wr;
    logic [15:0] init_val;
  } fpm_cfg_wr_t;

endpackage

@@ rtl/fpm_window.sv @@
`timescale 1ns / 1ps

module fpm_window import fpm_pkg::*; #(
  parameter int WINDOW_SLOTS = FPM_WINDOW_SLOTS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  fpm_evt_t    evt,
  output logic [15:0] sum_nxt,
  output logic [15:0] flow_hz,
  output logic [15:0] last_nonzero_hz
);

  localparam int POS_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;

  logic [15:0]      pulse_count_r, pulse_count_nxt;
  logic             blocked_r, blocked_nxt;
  logic [15:0]      ring_r [WINDOW_SLOTS];
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      sum_r, sum_nxt_int;
  logic [15:0]      last_r, last_nxt;

  // running sum: drop the slot being overwritten, add the fresh count
  assign sum_nxt = sum_r - ring_r[pos_r] + pulse_count_r;

  always_comb begin
    pulse_count_nxt = pulse_count_r;
    blocked_nxt     = blocked_r;
    pos_nxt         = pos_r;
    sum_nxt_int     = sum_r;
    last_nxt        = last_r;
    if (evt.pulse && !blocked_r) begin
      pulse_count_nxt = pulse_count_r + 16'd1;
      blocked_nxt     = 1'b1;
    end
    if (evt.filter_tick) begin
      blocked_nxt = 1'b0;
    end
    if (evt.period_tick) begin
      pulse_count_nxt = '0;
      sum_nxt_int     = sum_nxt;
      if (pos_r == POS_W'(WINDOW_SLOTS - 1)) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_r + 1'b1;
      end
      if (sum_nxt != 16'd0) begin
        last_nxt = sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_count_r <= '0;
      blocked_r     <= 1'b0;
      pos_r         <= '0;
      sum_r         <= '0;
      last_r        <= '0;
      for (int i = 0; i < WINDOW_SLOTS; i++) begin
        ring_r[i] <= '0;
      end
    end else begin
      pulse_count_r <= pulse_count_nxt;
      blocked_r     <= blocked_nxt;
      pos_r         <= pos_nxt;
      sum_r         <= sum_nxt_int;
      last_r        <= last_nxt;
      if (evt.period_tick) begin
        ring_r[pos_r] <= pulse_count_r;
      end
    end
  end

  assign flow_hz         = sum_r;
  assign last_nonzero_hz = last_r;

endmodule

@@ rtl/fpm_outage.sv @@
`timescale 1ns / 1ps

module fpm_outage import fpm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  fpm_evt_t    evt,
  input  logic [15:0] sum_nxt,
  input  logic [15:0] threshold,
  input  logic [15:0] wait_ticks,
  input  logic [15:0] check_ticks,
  input  logic        outage_kind,
  input  logic        outage_value,
  input  fpm_cfg_wr_t cfg_wr,
  output logic        outage_cold,
  output logic        outage_hot,
  output logic        checking_active
);

  logic        enabled_r, enabled_nxt;
  logic [15:0] wait_left_r, wait_left_nxt;
  logic [15:0] reload_r, reload_nxt;
  logic [15:0] check_left_r, check_left_nxt;
  logic        kind_r, kind_nxt;
  logic [1:0]  flags_r, flags_nxt;
  logic        start_seen_r, start_seen_nxt;

  always_comb begin
    enabled_nxt    = enabled_r;
    wait_left_nxt  = wait_left_r;
    reload_nxt     = reload_r;
    check_left_nxt = check_left_r;
    kind_nxt       = kind_r;
    flags_nxt      = flags_r;
    start_seen_nxt = start_seen_r;

    // initial reload only counts until the first start command
    if (cfg_wr.init_wr && !start_seen_r) begin
      reload_nxt     = cfg_wr.init_val;
      check_left_nxt = cfg_wr.init_val;
    end

    if (evt.period_tick) begin
      if (!enabled_r) begin
        check_left_nxt = reload_r;
      end else if (wait_left_r != 16'd0) begin
        wait_left_nxt = wait_left_r - 16'd1;
      end else if (sum_nxt <= threshold) begin
        if (check_left_r != 16'd0) begin
          check_left_nxt = check_left_r - 16'd1;
        end else begin
          flags_nxt[kind_r] = 1'b1;
        end
      end else begin
        check_left_nxt = reload_r;
      end
    end
    if (evt.start_check) begin
      enabled_nxt    = 1'b1;
      wait_left_nxt  = wait_ticks;
      reload_nxt     = check_ticks;
      check_left_nxt = check_ticks;
      kind_nxt       = outage_kind;
      start_seen_nxt = 1'b1;
    end
    if (evt.stop_check) begin
      enabled_nxt = 1'b0;
    end
    if (evt.set_outage) begin
      flags_nxt[outage_kind] = outage_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r    <= 1'b0;
      wait_left_r  <= '0;
      reload_r     <= FPM_INIT_TICKS_RESET;
      check_left_r <= FPM_INIT_TICKS_RESET;
      kind_r       <= 1'b0;
      flags_r      <= '0;
      start_seen_r <= 1'b0;
    end else begin
      enabled_r    <= enabled_nxt;
      wait_left_r  <= wait_left_nxt;
      reload_r     <= reload_nxt;
      check_left_r <= check_left_nxt;
      kind_r       <= kind_nxt;
      flags_r      <= flags_nxt;
      start_seen_r <= start_seen_nxt;
    end
  end

  assign outage_cold     = flags_r[0];
  assign outage_hot      = flags_r[1];
  assign checking_active = enabled_r;

endmodule

@@ rtl/flow_pulse_rate_and_outage_monitor.sv @@
`timescale 1ns / 1ps

// Flow pulse rate and outage monitor. Takes one word per clock unless
// in_stall is high: a word is captured in an input register and, once the
// result register is free or draining, updates the window and outage state,
// whose registers are presented as the result word. Sustained rate is one
// word per cycle while out_stall is low; the window sum is kept as a running
// total (drop the overwritten slot, add the new count), so every operation,
// including the period tick, is a single state update. While a result waits
// on out_stall one more word can sit in the input register. Register 0
// (address 0) is the low-flow threshold in Hz, register 1 (address 4) the
// initial check tick count; write them only while the block is idle.
module flow_pulse_rate_and_outage_monitor import fpm_pkg::*; #(
  parameter int WINDOW_SLOTS = FPM_WINDOW_SLOTS
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic [15:0] in_wait_ticks,
  input  logic [15:0] in_check_ticks,
  input  logic        in_outage_kind,
  input  logic        in_outage_value,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_flow_hz,
  output logic [15:0] out_last_nonzero_hz,
  output logic        out_outage_cold,
  output logic        out_outage_hot,
  output logic        out_checking_active,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        in_vld_r, in_vld_nxt;
  logic [2:0]  op_r;
  logic [15:0] wait_r;
  logic [15:0] check_r;
  logic        kind_r;
  logic        value_r;
  logic        out_vld_r, out_vld_nxt;
  logic        in_acc;
  logic        adv;
  fpm_evt_t    evt;

  logic [15:0] threshold_r;
  logic [15:0] init_ticks_r;
  logic        cfg_wr_en;
  fpm_reg_t    cfg_sel;
  fpm_cfg_wr_t cfg_wr;
  logic [15:0] sum_nxt;

  // state moves only when the result register is free or being drained
  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_acc) begin
      in_vld_nxt = 1'b1;
    end else if (adv) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (adv) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= in_operation;
      wait_r  <= in_wait_ticks;
      check_r <= in_check_ticks;
      kind_r  <= in_outage_kind;
      value_r <= in_outage_value;
    end
  end

  always_comb begin
    evt = '0;
    case (op_r)
      OP_PULSE:       evt.pulse       = adv;
      OP_FILTER_TICK: evt.filter_tick = adv;
      OP_PERIOD_TICK: evt.period_tick = adv;
      OP_START_CHECK: evt.start_check = adv;
      OP_STOP_CHECK:  evt.stop_check  = adv;
      OP_SET_OUTAGE:  evt.set_outage  = adv;
      default:        evt = '0;
    endcase
  end

  // register port
  assign pready    = 1'b1;
  assign cfg_sel   = fpm_reg_t'(paddr[2]);
  assign cfg_wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r  <= FPM_THRESHOLD_RESET;
      init_ticks_r <= FPM_INIT_TICKS_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_sel)
        REG_THRESHOLD:  threshold_r  <= pwdata[15:0];
        REG_INIT_TICKS: init_ticks_r <= pwdata[15:0];
        default:        threshold_r  <= threshold_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_THRESHOLD:  prdata = {16'd0, threshold_r};
      REG_INIT_TICKS: prdata = {16'd0, init_ticks_r};
      default:        prdata = '0;
    endcase
  end

  assign cfg_wr.init_wr  = cfg_wr_en && (cfg_sel == REG_INIT_TICKS);
  assign cfg_wr.init_val = pwdata[15:0];

  fpm_window #(
    .WINDOW_SLOTS (WINDOW_SLOTS)
  ) u_window (
    .clk             (clk),
    .rst_n           (rst_n),
    .evt             (evt),
    .sum_nxt         (sum_nxt),
    .flow_hz         (out_flow_hz),
    .last_nonzero_hz (out_last_nonzero_hz)
  );

  fpm_outage u_outage (
    .clk             (clk),
    .rst_n           (rst_n),
    .evt             (evt),
    .sum_nxt         (sum_nxt),
    .threshold       (threshold_r),
    .wait_ticks      (wait_r),
    .check_ticks     (check_r),
    .outage_kind     (kind_r),
    .outage_value    (value_r),
    .cfg_wr          (cfg_wr),
    .outage_cold     (out_outage_cold),
    .outage_hot      (out_outage_hot),
    .checking_active (out_checking_active)
  );

  assign out_valid = out_vld_r;

endmodule

@@ rtl/fpm_checker.sv @@
`timescale 1ns / 1ps
`include "flow_pulse_rate_and_outage_monitor_defines.svh"

module fpm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_flow_hz,
  input logic [15:0] out_last_nonzero_hz,
  input logic        out_outage_cold,
  input logic        out_outage_hot,
  input logic        out_checking_active
);

  logic [34:0] out_word;
  logic        flow_nz;
  logic        out_clear;

  assign out_word  = {out_flow_hz, out_last_nonzero_hz, out_outage_cold, out_outage_hot,
                      out_checking_active};
  assign flow_nz   = out_flow_hz != 16'd0;
  assign out_clear = !out_valid && !in_stall && (out_word == 35'd0);

  // a stalled result word holds
  `FPM_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_word), "held word moved")

  // a nonzero window sum is always the latest nonzero sum
  `FPM_ASSERT(a_last_tracks, flow_nz |-> out_last_nonzero_hz == out_flow_hz, "last sum lags")

  // reset clears out_valid, in_stall and the output word
  `FPM_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> out_clear, "state not cleared by reset")

endmodule

bind flow_pulse_rate_and_outage_monitor fpm_checker u_fpm_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_flow_hz         (out_flow_hz),
  .out_last_nonzero_hz (out_last_nonzero_hz),
  .out_outage_cold     (out_outage_cold),
  .out_outage_hot      (out_outage_hot),
  .out_checking_active (out_checking_active)
);

@@ tb/sv/flow_pulse_rate_and_outage_monitor_tb.sv @@
`timescale 1ns / 1ps

module flow_pulse_rate_and_outage_monitor_tb import fpm_pkg::*;;

  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_WORDS = 950;
  localparam int HOLD_CYCLES  = 120;

  // codes the block leaves unused
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] wait_ticks;
    logic [15:0] check_ticks;
    logic        kind;
    logic        value;
  } flow_word_t;

  typedef struct packed {
    logic [15:0] flow_hz;
    logic [15:0] last_nonzero_hz;
    logic        cold;
    logic        hot;
    logic        active;
  } flow_status_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_operation;
  logic [15:0] in_wait_ticks;
  logic [15:0] in_check_ticks;
  logic        in_outage_kind;
  logic        in_outage_value;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_flow_hz;
  logic [15:0] out_last_nonzero_hz;
  logic        out_outage_cold;
  logic        out_outage_hot;
  logic        out_checking_active;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  flow_pulse_rate_and_outage_monitor u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_wait_ticks       (in_wait_ticks),
    .in_check_ticks      (in_check_ticks),
    .in_outage_kind      (in_outage_kind),
    .in_outage_value     (in_outage_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_flow_hz         (out_flow_hz),
    .out_last_nonzero_hz (out_last_nonzero_hz),
    .out_outage_cold     (out_outage_cold),
    .out_outage_hot      (out_outage_hot),
    .out_checking_active (out_checking_active),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  // own copy of the monitor state
  logic [15:0] threshold_hz;
  logic [15:0] init_ticks;
  logic [15:0] pulse_cnt;
  logic        pulse_blocked;
  logic [15:0] slot_cnt [0:FPM_WINDOW_SLOTS-1];
  int          slot_pos;
  logic [15:0] win_sum;
  logic [15:0] last_nz_sum;
  logic        check_on;
  logic [15:0] wait_cnt;
  logic [15:0] check_reload;
  logic [15:0] check_cnt;
  logic        check_kind;
  logic        outage_flag [0:1];
  logic        start_seen;

  flow_status_t status_expected_q[$];
  int           mismatches;
  int           idle_cycles;
  int           hold_request;
  int           stall_left;
  bit           idle_enable;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic reset_prediction();
    threshold_hz  = FPM_THRESHOLD_RESET;
    init_ticks    = FPM_INIT_TICKS_RESET;
    pulse_cnt     = '0;
    pulse_blocked = 1'b0;
    for (int i = 0; i < FPM_WINDOW_SLOTS; i++) slot_cnt[i] = '0;
    slot_pos      = 0;
    win_sum       = '0;
    last_nz_sum   = '0;
    check_on      = 1'b0;
    wait_cnt      = '0;
    check_reload  = FPM_INIT_TICKS_RESET;
    check_cnt     = FPM_INIT_TICKS_RESET;
    check_kind    = 1'b0;
    outage_flag[0] = 1'b0;
    outage_flag[1] = 1'b0;
    start_seen    = 1'b0;
  endtask

  function automatic flow_status_t step_monitor(input flow_word_t w);
    logic [15:0]  dropped;
    flow_status_t s;
    case (w.op)
      OP_PULSE: begin
        if (!pulse_blocked) begin
          pulse_cnt     = pulse_cnt + 16'd1;
          pulse_blocked = 1'b1;
        end
      end
      OP_FILTER_TICK: pulse_blocked = 1'b0;
      OP_PERIOD_TICK: begin
        dropped           = slot_cnt[slot_pos];
        slot_cnt[slot_pos] = pulse_cnt;
        win_sum           = win_sum - dropped + pulse_cnt;
        pulse_cnt         = '0;
        slot_pos          = (slot_pos + 1 >= FPM_WINDOW_SLOTS) ? 0 : slot_pos + 1;
        if (win_sum != 16'd0) last_nz_sum = win_sum;
        if (!check_on) begin
          check_cnt = check_reload;
        end else if (wait_cnt != 16'd0) begin
          wait_cnt = wait_cnt - 16'd1;
        end else if (win_sum <= threshold_hz) begin
          if (check_cnt != 16'd0) check_cnt = check_cnt - 16'd1;
          else outage_flag[check_kind] = 1'b1;
        end else begin
          check_cnt = check_reload;
        end
      end
      OP_START_CHECK: begin
        check_on     = 1'b1;
        wait_cnt     = w.wait_ticks;
        check_reload = w.check_ticks;
        check_cnt    = w.check_ticks;
        check_kind   = w.kind;
        start_seen   = 1'b1;
      end
      OP_STOP_CHECK: check_on = 1'b0;
      OP_SET_OUTAGE: outage_flag[w.kind] = w.value;
      default: ;
    endcase
    s.flow_hz         = win_sum;
    s.last_nonzero_hz = last_nz_sum;
    s.cold            = outage_flag[0];
    s.hot             = outage_flag[1];
    s.active          = check_on;
    return s;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idle_enable) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_word(input logic [2:0] op, input logic [15:0] wt, input logic [15:0] ct,
                           input logic k, input logic v);
    flow_word_t w;
    int         gap;
    w = '{op: op, wait_ticks: wt, check_ticks: ct, kind: k, value: v};
    @(negedge clk);
    in_valid        = 1'b1;
    in_operation    = op;
    in_wait_ticks   = wt;
    in_check_ticks  = ct;
    in_outage_kind  = k;
    in_outage_value = v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    status_expected_q.push_back(step_monitor(w));
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // fields other than the operation carry random content
  task automatic send_op(input logic [2:0] op);
    send_word(op, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (status_expected_q.size() > 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input fpm_reg_t idx, input logic [15:0] data);
    wait_drain();
    @(negedge clk);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = {16'h0000, data};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_THRESHOLD) begin
      threshold_hz = data;
    end else begin
      init_ticks = data;
      if (!start_seen) begin
        check_reload = data;
        check_cnt    = data;
      end
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // receiver side: long hold on request, otherwise random stalls
  initial begin
    out_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        out_stall    = 1'b1;
        hold_request = hold_request - 1;
      end else if (stall_left > 0) begin
        out_stall  = 1'b1;
        stall_left = stall_left - 1;
      end else begin
        out_stall  = 1'b0;
        stall_left = pick_gap();
      end
    end
  end

  task automatic check_status_field(input string label, input logic [15:0] exp_val,
                                    input logic [15:0] got_val);
    if (got_val !== exp_val) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, label, exp_val, got_val);
    end
  endtask

  always @(posedge clk) begin
    flow_status_t exp_s;
    if (rst_n && out_valid && !out_stall) begin
      if (status_expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word expected none actual flow %0d last %0d",
                 $time, out_flow_hz, out_last_nonzero_hz);
        $display("  cold %0d hot %0d active %0d", out_outage_cold, out_outage_hot,
                 out_checking_active);
      end else begin
        exp_s = status_expected_q.pop_front();
        check_status_field("flow_hz", exp_s.flow_hz, out_flow_hz);
        check_status_field("last_nonzero_hz", exp_s.last_nonzero_hz, out_last_nonzero_hz);
        check_status_field("outage_cold", 16'(exp_s.cold), 16'(out_outage_cold));
        check_status_field("outage_hot", 16'(exp_s.hot), 16'(out_outage_hot));
        check_status_field("checking_active", 16'(exp_s.active), 16'(out_checking_active));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no word moved for %0d cycles, %0d results outstanding", $time,
               idle_cycles, status_expected_q.size());
      $display("flow_pulse_rate_and_outage_monitor: mismatch");
      $finish;
    end
  end

  task automatic test_register_extremes();
    // before any start check the reload value follows the register
    write_reg(REG_INIT_TICKS, 16'd0);
    write_reg(REG_INIT_TICKS, 16'hFFFF);
    write_reg(REG_THRESHOLD, 16'hFFFF);
    write_reg(REG_THRESHOLD, 16'd0);
    write_reg(REG_THRESHOLD, FPM_THRESHOLD_RESET);
  endtask

  task automatic test_directed_ops();
    send_word(OP_PULSE, 16'h0000, 16'h0000, 1'b0, 1'b0);
    send_word(OP_PULSE, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);  // blocked
    send_word(OP_FILTER_TICK, 16'h0000, 16'h0000, 1'b0, 1'b0);
    send_word(OP_PULSE, 16'h0000, 16'h0000, 1'b0, 1'b0);
    send_word(OP_PERIOD_TICK, 16'h0000, 16'h0000, 1'b0, 1'b0);
    send_word(OP_SPARE_6, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
    send_word(OP_SPARE_7, 16'h0000, 16'h0000, 1'b0, 1'b0);
    send_word(OP_SET_OUTAGE, 16'h0000, 16'h0000, 1'b0, 1'b1);
    send_word(OP_SET_OUTAGE, 16'h0000, 16'h0000, 1'b1, 1'b1);
    send_word(OP_SET_OUTAGE, 16'h0000, 16'h0000, 1'b0, 1'b0);
    send_word(OP_SET_OUTAGE, 16'h0000, 16'h0000, 1'b1, 1'b0);
    // zero wait and zero count: first low tick raises the hot flag
    send_word(OP_START_CHECK, 16'h0000, 16'h0000, 1'b1, 1'b1);
    send_word(OP_PERIOD_TICK, 16'h0000, 16'h0000, 1'b0, 1'b0);
    send_word(OP_SET_OUTAGE, 16'h0000, 16'h0000, 1'b1, 1'b0);
    send_word(OP_PERIOD_TICK, 16'h0000, 16'h0000, 1'b0, 1'b0);  // expired, sets again
    send_word(OP_STOP_CHECK, 16'h0000, 16'h0000, 1'b0, 1'b0);
    send_word(OP_PERIOD_TICK, 16'h0000, 16'h0000, 1'b0, 1'b0);  // off, reloads count
    send_word(OP_START_CHECK, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
    send_word(OP_PERIOD_TICK, 16'h0000, 16'h0000, 1'b0, 1'b0);
    send_word(OP_SET_OUTAGE, 16'h0000, 16'h0000, 1'b1, 1'b1);
    send_word(OP_STOP_CHECK, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
    send_word(OP_SET_OUTAGE, 16'h0000, 16'h0000, 1'b1, 1'b0);
  endtask

  task automatic send_pulse_period(input int pulses);
    repeat (pulses) begin
      send_op(OP_PULSE);
      send_op(OP_FILTER_TICK);
    end
    send_op(OP_PERIOD_TICK);
  endtask

  task automatic test_ring_wrap();
    wait_drain();
    // slot counts differ, so dropping the wrong slot on wrap shows in the sum
    for (int i = 0; i < 2 * FPM_WINDOW_SLOTS + 3; i++) send_pulse_period(i % 4);
  endtask

  task automatic test_receiver_hold();
    wait_drain();
    idle_enable  = 1'b0;
    hold_request = HOLD_CYCLES;
    repeat (10) begin
      send_op(OP_PULSE);
      send_op(OP_FILTER_TICK);
      send_op(OP_PULSE);
      send_op(OP_PERIOD_TICK);
    end
    idle_enable = 1'b1;
  endtask

  task automatic test_sender_pause();
    send_pulse_period(3);
    send_op(OP_START_CHECK);
    wait_drain();
    send_pulse_period(1);
    send_op(OP_STOP_CHECK);
  endtask

  function automatic int pick_pulse_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(9, 40);
  endfunction

  task automatic change_settings();
    int r;
    r = $urandom_range(0, 3);
    case (r)
      0: write_reg(REG_THRESHOLD, 16'd0);
      1: write_reg(REG_THRESHOLD, 16'hFFFF);
      2: write_reg(REG_THRESHOLD, 16'($urandom_range(0, 65535)));
      default: write_reg(REG_THRESHOLD, 16'($urandom_range(0, 10)));
    endcase
    if ($urandom_range(0, 2) == 0) write_reg(REG_INIT_TICKS, 16'($urandom_range(0, 65535)));
  endtask

  task automatic test_random_traffic();
    int counted;
    int r;
    int n;
    counted = 0;
    while (counted < RANDOM_WORDS) begin
      if ($urandom_range(0, 99) < 3) idle_enable = !idle_enable;
      r = $urandom_range(0, 99);
      if (r < 65) begin
        n = pick_pulse_count();
        repeat (n) begin
          send_op(OP_PULSE);
          if ($urandom_range(0, 4) == 0) send_op(OP_PULSE);
          // a missing filter tick leaves the next pulse blocked
          if ($urandom_range(0, 9) != 0) send_op(OP_FILTER_TICK);
          counted += 2;
        end
        send_op(OP_PERIOD_TICK);
        counted++;
      end else if (r < 75) begin
        if ($urandom_range(0, 99) < 85)
          send_word(OP_START_CHECK, 16'($urandom_range(0, 3)), 16'($urandom_range(0, 4)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        else
          send_op(OP_START_CHECK);
        counted++;
      end else if (r < 80) begin
        send_op(OP_STOP_CHECK);
        counted++;
      end else if (r < 86) begin
        send_op(OP_SET_OUTAGE);
        counted++;
      end else if (r < 88) begin
        change_settings();
      end else begin
        send_op(3'($urandom_range(0, 7)));
        counted++;
      end
    end
    idle_enable = 1'b1;
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_operation    = OP_PULSE;
    in_wait_ticks   = '0;
    in_check_ticks  = '0;
    in_outage_kind  = 1'b0;
    in_outage_value = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    mismatches      = 0;
    idle_cycles     = 0;
    hold_request    = 0;
    idle_enable     = 1'b1;
    reset_prediction();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_register_extremes();
    test_directed_ops();
    test_receiver_hold();
    test_sender_pause();
    test_ring_wrap();
    test_random_traffic();

    wait_drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("flow_pulse_rate_and_outage_monitor: match");
    end else begin
      $display("flow_pulse_rate_and_outage_monitor: mismatch");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/fpm_pkg.sv
rtl/fpm_window.sv
rtl/fpm_outage.sv
rtl/flow_pulse_rate_and_outage_monitor.sv
rtl/fpm_checker.sv
tb/sv/flow_pulse_rate_and_outage_monitor_tb.sv
